// ===== rtl/sid_pkg.sv =====
// Package for the signed integer divider.
// Holds widths, mode codes and the pipeline stage record; no dependencies.
package sid_pkg;

    localparam int DataWidth  = 64;
    localparam int HalfWidth  = 32;
    localparam int BitsPerStg = 4;
    localparam int NumStages  = DataWidth / BitsPerStg;

    typedef enum logic [1:0] {
        MODE_32_32 = 2'd0,
        MODE_64_32 = 2'd1,
        MODE_64_64 = 2'd2,
        MODE_64_64B = 2'd3
    } mode_t;

    // Item record carried along the pipeline
    typedef struct packed {
        logic [DataWidth-1:0] rem;
        logic [DataWidth-1:0] quo;
        logic [DataWidth-1:0] divisor;
        logic [DataWidth-1:0] eff_num;
        logic                 neg_q;
        logic                 neg_r;
        logic                 zero_div;
        logic                 narrow;
        logic                 dbz;
    } stage_t;

endpackage

// ===== rtl/sid_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface sid_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/signed_integer_divider.sv =====
// Signed divider top level: 64/64, 64/32 and 32/32 modes, truncating.
// Depends on sid_pkg and sid_if.
//
// Restoring division pipeline: one request is accepted every cycle when the
// output side takes results. The stages are one input stage that
// selects and takes magnitudes, 16 stages each retiring four quotient bits,
// and one output stage that fixes signs and special cases. The pipeline
// stalls as a whole when the output register holds an untaken result.
module signed_integer_divider
    import sid_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sid_if.sink  in_ch,
    sid_if.source out_ch
);

    typedef struct packed {
        logic [DataWidth-1:0] numerator;
        logic [DataWidth-1:0] denominator;
        logic [1:0]           mode;
    } in_t;

    typedef struct packed {
        logic [DataWidth-1:0] quotient;
        logic [DataWidth-1:0] remainder;
        logic                 div_by_zero;
    } out_t;

    stage_t                 stg_reg   [NumStages+1];
    stage_t                 stg_in_next;
    stage_t                 stg_next  [1:NumStages];
    logic   [NumStages+1:0] vld_reg;
    out_t                   out_reg;
    out_t                   out_next;
    logic                   advance;
    in_t                    req;

    assign req     = in_ch.payload;
    assign advance = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = advance;
    assign out_ch.valid = vld_reg[NumStages+1];
    assign out_ch.payload = out_reg;

    // Input stage: effective operands and magnitudes
    always_comb
    begin
        logic [DataWidth-1:0] a;
        logic [DataWidth-1:0] b;
        a = req.numerator;
        b = req.denominator;
        if (mode_t'(req.mode) == MODE_32_32)
        begin
            a = {{HalfWidth{req.numerator[HalfWidth-1]}}, req.numerator[HalfWidth-1:0]};
            b = {{HalfWidth{req.denominator[HalfWidth-1]}}, req.denominator[HalfWidth-1:0]};
        end
        else if (mode_t'(req.mode) == MODE_64_32)
        begin
            b = {{HalfWidth{req.denominator[HalfWidth-1]}}, req.denominator[HalfWidth-1:0]};
        end
        stg_in_next.eff_num  = a;
        stg_in_next.rem      = a[DataWidth-1] ? -a : a;
        stg_in_next.quo      = '0;
        stg_in_next.divisor  = b[DataWidth-1] ? -b : b;
        stg_in_next.neg_q    = a[DataWidth-1] ^ b[DataWidth-1];
        stg_in_next.neg_r    = a[DataWidth-1];
        stg_in_next.zero_div = (b == '0);
        stg_in_next.narrow   = (mode_t'(req.mode) == MODE_32_32);
        stg_in_next.dbz      = (req.denominator == '0);
    end

    // Iteration stages: the dividend shifts into the partial remainder from
    // the quotient field, four bits per stage
    always_comb
    begin
        logic [DataWidth:0]   pr;
        logic [DataWidth-1:0] qw;
        logic [DataWidth:0]   diff;
        for (int s = 1; s <= NumStages; s++)
        begin
            stg_next[s] = stg_reg[s-1];
            if (s == 1)
            begin
                pr = '0;
                qw = stg_reg[0].rem;
            end
            else
            begin
                pr = {1'b0, stg_reg[s-1].rem};
                qw = stg_reg[s-1].quo;
            end
            for (int k = 0; k < BitsPerStg; k++)
            begin
                pr   = {pr[DataWidth-1:0], qw[DataWidth-1]};
                diff = pr - {1'b0, stg_reg[s-1].divisor};
                qw   = {qw[DataWidth-2:0], !diff[DataWidth]};
                if (!diff[DataWidth])
                    pr = diff;
            end
            stg_next[s].rem = pr[DataWidth-1:0];
            stg_next[s].quo = qw;
        end
    end

    // Output stage: signs and zero-divisor results
    always_comb
    begin
        stage_t f;
        f = stg_reg[NumStages];
        out_next.div_by_zero = f.dbz;
        if (f.zero_div)
        begin
            out_next.quotient = f.eff_num[DataWidth-1] ? DataWidth'(1) : '1;
            if (f.narrow)
                out_next.quotient = out_next.quotient ^ {{HalfWidth{1'b1}}, {HalfWidth{1'b0}}};
            out_next.remainder = f.eff_num;
        end
        else
        begin
            out_next.quotient  = f.neg_q ? -f.quo : f.quo;
            out_next.remainder = f.neg_r ? -f.rem : f.rem;
        end
    end

    // Pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NumStages:0], in_ch.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stg_reg[0] <= stg_in_next;
            for (int s = 1; s <= NumStages; s++)
                stg_reg[s] <= stg_next[s];
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/sid_checker.sv =====
// Port-level checks for the signed integer divider.
// Depends on sid_pkg; bound to signed_integer_divider.
module sid_checker
    import sid_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [DataWidth-1:0] quotient,
    input logic [DataWidth-1:0] remainder,
    input logic div_by_zero
);
    // A stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(remainder))
        else $error("stalled result changed");

    // The block takes requests whenever its output is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("not ready with empty output");

    // Ready is low while the output holds a stalled result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("accepted while stalled");

    // Zero denominator never gives a zero remainder flag mismatch: a flagged
    // result with zero remainder must have all ones in the quotient's low half
    a_dbz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero && remainder == '0 |->
            quotient[HalfWidth-1:0] == '1)
        else $error("zero divisor quotient wrong");
endmodule

bind signed_integer_divider sid_checker u_sid_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .quotient   (out_ch.payload[128:65]),
    .remainder  (out_ch.payload[64:1]),
    .div_by_zero(out_ch.payload[0])
);

// ===== tb/div_tb_pkg.sv =====
// Request and result records shared by the divider testbench modules.
// Depends on sid_pkg for the widths and the mode codes.
package div_tb_pkg;

    import sid_pkg::*;

    // One division request as carried on the input channel
    typedef struct packed {
        logic [DataWidth-1:0] numerator;
        logic [DataWidth-1:0] denominator;
        mode_t                mode;
    } div_request_t;

    // One division result as carried on the output channel
    typedef struct packed {
        logic [DataWidth-1:0] quotient;
        logic [DataWidth-1:0] remainder;
        logic                 div_by_zero;
    } div_result_t;

    localparam logic [DataWidth-1:0] UpperHalfMask = 64'hffff_ffff_0000_0000;
    localparam logic [DataWidth-1:0] MinValue      = 64'h8000_0000_0000_0000;
    localparam logic [DataWidth-1:0] MaxValue      = 64'h7fff_ffff_ffff_ffff;

endpackage

// ===== tb/div_checker.sv =====
// Checker for the signed divider: predicts each result from the accepted
// requests and compares it with the result taken. Depends on div_tb_pkg.
module div_checker
    import sid_pkg::*;
    import div_tb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic         req_ready,
    input  div_request_t req_payload,
    input  logic         res_valid,
    input  logic         res_ready,
    input  div_result_t  res_payload,
    output int           fail_count,
    output int           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    div_result_t expected_results[$];

    // Truncating signed division with the block's zero-divisor conventions
    function automatic div_result_t predict_division(div_request_t req);
        logic [DataWidth-1:0] a, b, ua, ub, uq, ur;
        logic na, nb;
        div_result_t res;
        a = req.numerator;
        b = req.denominator;
        if (req.mode == MODE_32_32)
        begin
            a = {{HalfWidth{a[HalfWidth-1]}}, a[HalfWidth-1:0]};
            b = {{HalfWidth{b[HalfWidth-1]}}, b[HalfWidth-1:0]};
        end
        else if (req.mode == MODE_64_32)
        begin
            b = {{HalfWidth{b[HalfWidth-1]}}, b[HalfWidth-1:0]};
        end
        if (b == '0)
        begin
            res.quotient = a[DataWidth-1] ? 64'd1 : '1;
            if (req.mode == MODE_32_32)
            begin
                res.quotient = res.quotient ^ UpperHalfMask;
            end
            res.remainder = a;
        end
        else
        begin
            na = a[DataWidth-1];
            nb = b[DataWidth-1];
            ua = na ? -a : a;
            ub = nb ? -b : b;
            uq = ua / ub;
            ur = ua % ub;
            res.quotient  = (na != nb) ? -uq : uq;
            res.remainder = na ? -ur : ur;
        end
        res.div_by_zero = (req.denominator == '0);
        return res;
    endfunction

    assign pending_count = expected_results.size();

    // Record requests and compare results at each accepting edge
    always @(posedge clk or negedge rst_n)
    begin
        div_result_t exp_res;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_results.push_back(predict_division(req_payload));
            end
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result q=%h r=%h dbz=%b", $time,
                             res_payload.quotient, res_payload.remainder,
                             res_payload.div_by_zero);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.quotient !== res_payload.quotient)
                    begin
                        $display("%0t: quotient expected %h actual %h", $time,
                                 exp_res.quotient, res_payload.quotient);
                    end
                    if (exp_res.remainder !== res_payload.remainder)
                    begin
                        $display("%0t: remainder expected %h actual %h", $time,
                                 exp_res.remainder, res_payload.remainder);
                    end
                    if (exp_res.div_by_zero !== res_payload.div_by_zero)
                    begin
                        $display("%0t: div_by_zero expected %b actual %b", $time,
                                 exp_res.div_by_zero, res_payload.div_by_zero);
                    end
                    if (exp_res !== res_payload)
                    begin
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_signed_integer_divider.sv =====
// Top of the signed divider testbench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on sid_pkg, div_tb_pkg, div_checker, sid_if and signed_integer_divider.
module tb_signed_integer_divider;
    import sid_pkg::*;
    import div_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomRequests = 750;
    localparam int CycleLimit     = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   send_idle_pct;
    int   take_idle_pct;

    sid_if #(.payload_t(div_request_t)) in_ch ();
    sid_if #(.payload_t(div_result_t))  out_ch ();

    signed_integer_divider i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    div_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (in_ch.valid),
        .req_ready    (in_ch.ready),
        .req_payload  (in_ch.payload),
        .res_valid    (out_ch.valid),
        .res_ready    (out_ch.ready),
        .res_payload  (out_ch.payload),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // Clock generation
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random stalls on the result side
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one request and hold it until it is accepted; each cycle
    // before it idles with the sender's idle share
    task automatic send_request(input logic [63:0] num, input logic [63:0] den,
                                input mode_t mode);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid               <= 1'b1;
        in_ch.payload.numerator   <= num;
        in_ch.payload.denominator <= den;
        in_ch.payload.mode        <= mode;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Operand with a bias towards boundaries, small values and zero halves
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = {$urandom_range(1) ? 8'hff : 8'h00, 56'd0} |
                   ($urandom_range(1) ? 64'd1 : 64'd0);
            1: v = 64'($signed($urandom_range(20)) - 10);
            2: v = {v[63:32], 32'd0};
            3: v = {{32{v[31]}}, v[31:0]};
            4: v = $urandom_range(1) ? MinValue : MaxValue;
            5: v = {$urandom_range(1) ? 32'hffff_ffff : 32'd0, 1'b1, 31'd0};
            default: ;
        endcase
        return v;
    endfunction

    // Stimulus and verdict
    initial
    begin
        mode_t m;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        send_idle_pct = 31;
        take_idle_pct = 72;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, zero divisors and overflow cases in every mode
        send_request(MaxValue, 64'd7, MODE_64_64);
        send_request(MinValue, 64'd7, MODE_64_64B);
        send_request(MinValue, '1, MODE_64_64);
        send_request(MinValue, '1, MODE_64_64B);
        send_request(MinValue, '1, MODE_64_32);
        send_request(64'h0000_0000_8000_0000, '1, MODE_32_32);
        send_request(64'h1234_5678_8000_0000, 64'h0000_0000_ffff_ffff, MODE_32_32);
        send_request(64'd100, 64'd0, MODE_32_32);
        send_request(-64'd100, 64'd0, MODE_32_32);
        send_request(64'd100, 64'd0, MODE_64_32);
        send_request(-64'd100, 64'd0, MODE_64_64);
        send_request(64'd0, 64'd0, MODE_64_64B);
        send_request(64'h0000_0001_0000_0005, 64'h0000_0001_0000_0000, MODE_32_32);
        send_request(64'hffff_ffff_8000_0005, 64'h0000_0001_0000_0000, MODE_64_32);
        send_request(64'h0000_0001_0000_0005, 64'h0000_0001_0000_0000, MODE_64_64);
        send_request(-64'd7, 64'd2, MODE_64_64);
        send_request(64'd7, -64'd2, MODE_64_32);
        send_request(-64'd7, -64'd2, MODE_32_32);
        send_request('1, '1, MODE_64_64B);
        send_request(MaxValue, MinValue, MODE_64_64);
        send_request(MinValue, MinValue, MODE_64_64);
        send_request(MaxValue, 64'd1, MODE_64_32);
        send_request(64'hffff_ffff_7fff_ffff, 64'h8000_0000_8000_0000, MODE_32_32);

        // Hold off until the pipeline has drained completely
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);

        // Random requests in three idling phases
        for (int i = 0; i < RandomRequests; i++)
        begin
            if (i == RandomRequests / 3)
            begin
                send_idle_pct = 72;
                take_idle_pct = 31;
            end
            if (i == 2 * RandomRequests / 3)
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            m = mode_t'($urandom_range(3));
            send_request(pick_operand(), pick_operand(), m);
        end
        in_ch.valid <= 1'b0;

        // Drain, then idle before the verdict
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sid_pkg.sv
rtl/sid_if.sv
rtl/signed_integer_divider.sv
rtl/sid_checker.sv
tb/div_tb_pkg.sv
tb/div_checker.sv
tb/tb_signed_integer_divider.sv
